[hw/rtl/lcdws_pkg.sv]
package lcdws_pkg;

  // request codes on in_cmd
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_BYTE   = 3'd1;
  localparam logic [2:0] CMD_DATA   = 3'd2;
  localparam logic [2:0] CMD_CURSOR = 3'd3;
  localparam logic [2:0] CMD_INIT   = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_LINE0_OFFSET   = 3'd0;
  localparam logic [2:0] REG_LINE1_OFFSET   = 3'd1;
  localparam logic [2:0] REG_POWER_UP_TICKS = 3'd2;
  localparam logic [2:0] REG_STEP_TICKS     = 3'd3;
  localparam logic [2:0] REG_LONG_CMD_TICKS = 3'd4;

  // lcd command bytes
  localparam logic [7:0] LCD_CLS      = 8'h01;
  localparam logic [7:0] LCD_HOME     = 8'h02;
  localparam logic [7:0] LCD_FUNC_SET = 8'h38;
  localparam logic [7:0] LCD_DISP_OFF = 8'h08;
  localparam logic [7:0] LCD_ENTRY    = 8'h06;
  localparam logic [7:0] LCD_DISP_ON  = 8'h0C;

  localparam logic [7:0] MAX_COL     = 8'd15;
  localparam logic [2:0] INIT_FIRST  = 3'd1;
  localparam logic [2:0] INIT_LAST   = 3'd5;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_POWERUP = 7'b0000010,
    PH_RS      = 7'b0000100,
    PH_DATA    = 7'b0001000,
    PH_EHIGH   = 7'b0010000,
    PH_HOLD    = 7'b0100000,
    PH_LONG    = 7'b1000000
  } phase_t;

  // init byte sent as the idx-th byte of the init sequence (1 based)
  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd1:    b = LCD_FUNC_SET;
      3'd2:    b = LCD_DISP_OFF;
      3'd3:    b = LCD_CLS;
      3'd4:    b = LCD_ENTRY;
      3'd5:    b = LCD_DISP_ON;
      default: b = LCD_FUNC_SET;
    endcase
    return b;
  endfunction

endpackage

[hw/rtl/char_lcd_write_sequencer.sv]
// Character LCD write sequencer for the 8-bit parallel write-only bus.
// Input channel (in_valid/in_ready): one transaction is one millisecond tick
// carrying a request code (tick, command byte, data byte, set cursor, init)
// with its value, row and column. A request taken while a sequence runs is
// rejected and only counts as one tick of that sequence.
// Output channel (out_valid/out_ready): one transaction per input, giving the
// RS, E and data pin levels after that tick, the busy flag and whether the
// request was taken. Throughput is one transaction per cycle unless stalled.
// The pin and sequence state registers are the result register itself, and
// in_ready is high whenever the result slot is empty or being drained in the
// same cycle. If the receiver stalls, the result holds and input is stalled
// with it. Configuration (cfg_we/cfg_index/cfg_data) must be written while
// idle only; the block does not enforce it. Synchronous active-low reset
// returns to idle with all pins low and the registers at line offsets 0/64,
// power-up 50, step 1, long delay 2 ticks.
module char_lcd_write_sequencer
  import lcdws_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_cmd,
  input  logic [7:0] in_value,
  input  logic [1:0] in_row,
  input  logic [7:0] in_col,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_pin_rs,
  output logic       out_pin_enable,
  output logic [7:0] out_pin_data,
  output logic       out_busy_res,
  output logic       out_accepted,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [6:0] line0_r, line1_r;
  logic [7:0] power_up_r;
  logic [3:0] step_r, long_r;

  phase_t     phase_r, phase_nxt;
  logic [7:0] wait_r, wait_nxt;
  logic [7:0] held_byte_r, held_byte_nxt;
  logic       held_is_data_r, held_is_data_nxt;
  logic [2:0] init_r, init_nxt;
  logic       rs_r, rs_nxt;
  logic       en_r, en_nxt;
  logic [7:0] data_r, data_nxt;
  logic       acc_r, acc_nxt;
  logic       out_valid_r;

  logic       take;
  logic [3:0] step_len;
  logic [7:0] step1, step2;
  logic [7:0] wc_dec;
  logic       do_start, start_is_data, do_fin;
  logic [7:0] start_byte;
  logic [3:0] cur_col;
  logic [6:0] cur_base, cur_addr;

  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;

  assign step_len = (step_r == 4'd0) ? 4'd1 : step_r;
  assign step1    = {4'd0, step_len};
  assign step2    = {3'd0, step_len, 1'b0};

  assign cur_col  = (in_col > MAX_COL) ? 4'd0 : in_col[3:0];
  assign cur_base = (in_row == 2'd1) ? line1_r : line0_r;
  assign cur_addr = cur_base + {3'd0, cur_col};

  always_comb begin
    phase_nxt        = phase_r;
    wait_nxt         = wait_r;
    held_byte_nxt    = held_byte_r;
    held_is_data_nxt = held_is_data_r;
    init_nxt         = init_r;
    rs_nxt           = rs_r;
    en_nxt           = en_r;
    data_nxt         = data_r;
    acc_nxt          = 1'b0;
    do_start         = 1'b0;
    start_byte       = 8'd0;
    start_is_data    = 1'b0;
    do_fin           = 1'b0;
    wc_dec           = (wait_r != 8'd0) ? wait_r - 8'd1 : 8'd0;

    if (phase_r != PH_IDLE) begin
      wait_nxt = wc_dec;
      if (wc_dec == 8'd0) begin
        case (phase_r)
          PH_POWERUP: begin
            rs_nxt     = 1'b0;
            en_nxt     = 1'b0;
            init_nxt   = INIT_FIRST;
            do_start   = 1'b1;
            start_byte = init_byte(INIT_FIRST);
          end
          PH_RS: begin
            data_nxt  = held_byte_r;
            phase_nxt = PH_DATA;
            wait_nxt  = step2;
          end
          PH_DATA: begin
            en_nxt    = 1'b1;
            phase_nxt = PH_EHIGH;
            wait_nxt  = step1;
          end
          PH_EHIGH: begin
            en_nxt    = 1'b0;
            phase_nxt = PH_HOLD;
            wait_nxt  = step2;
          end
          PH_HOLD: begin
            if (!held_is_data_r && (held_byte_r == LCD_CLS || held_byte_r == LCD_HOME)) begin
              phase_nxt = PH_LONG;
              wait_nxt  = {4'd0, long_r};
              // a zero long delay finishes in the same tick
              do_fin    = (long_r == 4'd0);
            end else begin
              do_fin = 1'b1;
            end
          end
          default: do_fin = 1'b1;
        endcase
      end
    end else if (in_cmd inside {[CMD_BYTE:CMD_INIT]}) begin
      acc_nxt = 1'b1;
      case (in_cmd)
        CMD_BYTE: begin
          do_start   = 1'b1;
          start_byte = in_value;
        end
        CMD_DATA: begin
          do_start      = 1'b1;
          start_byte    = in_value;
          start_is_data = 1'b1;
        end
        CMD_CURSOR: begin
          do_start   = 1'b1;
          start_byte = {1'b1, cur_addr};
        end
        default: begin
          if (power_up_r == 8'd0) begin
            rs_nxt     = 1'b0;
            en_nxt     = 1'b0;
            init_nxt   = INIT_FIRST;
            do_start   = 1'b1;
            start_byte = init_byte(INIT_FIRST);
          end else begin
            init_nxt  = 3'd0;
            phase_nxt = PH_POWERUP;
            wait_nxt  = power_up_r;
          end
        end
      endcase
    end

    if (do_fin) begin
      if (init_nxt inside {[INIT_FIRST:INIT_LAST - 3'd1]}) begin
        init_nxt   = init_nxt + 3'd1;
        do_start   = 1'b1;
        start_byte = init_byte(init_nxt);
      end else begin
        init_nxt  = 3'd0;
        phase_nxt = PH_IDLE;
        wait_nxt  = 8'd0;
      end
    end

    if (do_start) begin
      held_byte_nxt    = start_byte;
      held_is_data_nxt = start_is_data;
      rs_nxt           = start_is_data;
      phase_nxt        = PH_RS;
      wait_nxt         = step1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line0_r    <= 7'd0;
      line1_r    <= 7'd64;
      power_up_r <= 8'd50;
      step_r     <= 4'd1;
      long_r     <= 4'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE0_OFFSET:   line0_r    <= cfg_data[6:0];
        REG_LINE1_OFFSET:   line1_r    <= cfg_data[6:0];
        REG_POWER_UP_TICKS: power_up_r <= cfg_data;
        REG_STEP_TICKS:     step_r     <= cfg_data[3:0];
        REG_LONG_CMD_TICKS: long_r     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      wait_r         <= 8'd0;
      held_byte_r    <= 8'd0;
      held_is_data_r <= 1'b0;
      init_r         <= 3'd0;
      rs_r           <= 1'b0;
      en_r           <= 1'b0;
      data_r         <= 8'd0;
      acc_r          <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (take) begin
        phase_r        <= phase_nxt;
        wait_r         <= wait_nxt;
        held_byte_r    <= held_byte_nxt;
        held_is_data_r <= held_is_data_nxt;
        init_r         <= init_nxt;
        rs_r           <= rs_nxt;
        en_r           <= en_nxt;
        data_r         <= data_nxt;
        acc_r          <= acc_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pin_rs     = rs_r;
  assign out_pin_enable = en_r;
  assign out_pin_data   = data_r;
  assign out_busy_res   = (phase_r != PH_IDLE);
  assign out_accepted   = acc_r;

  // the strobe is high exactly while in the pulse phase
  a_enable_phase: assert property (@(posedge clk) disable iff (!rst_n)
    en_r == (phase_r == PH_EHIGH))
    else $error("enable level out of step with phase");

  // init sequence position only lives inside a running sequence
  a_init_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (init_r != 3'd0) |-> (phase_r != PH_IDLE && init_r <= INIT_LAST))
    else $error("init index set while idle");

  // a taken request always leaves the block busy
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && acc_r) |-> (phase_r != PH_IDLE))
    else $error("accepted request without running sequence");

  // a transaction arriving while busy is never reported as taken
  a_busy_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (take && phase_r != PH_IDLE) |=> !acc_r)
    else $error("request accepted while busy");

endmodule

[tb/sv/tb_char_lcd_write_sequencer.sv]
module tb_char_lcd_write_sequencer;
  import lcdws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] value;
    logic [1:0] row;
    logic [7:0] col;
  } lcd_req_t;

  typedef struct packed {
    logic       rs;
    logic       en;
    logic [7:0] data;
    logic       busy;
    logic       taken;
  } pin_state_t;

  // bytes of the power-on sequence, element i is the i-th byte sent
  localparam logic [5:1][7:0] INIT_SEQ =
    {LCD_DISP_ON, LCD_ENTRY, LCD_CLS, LCD_DISP_OFF, LCD_FUNC_SET};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_cmd = CMD_TICK;
  logic [7:0] in_value = 8'd0;
  logic [1:0] in_row = 2'd0;
  logic [7:0] in_col = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_pin_rs;
  logic       out_pin_enable;
  logic [7:0] out_pin_data;
  logic       out_busy_res;
  logic       out_accepted;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_LINE0_OFFSET;
  logic [7:0] cfg_data = 8'd0;

  char_lcd_write_sequencer dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_value      (in_value),
    .in_row        (in_row),
    .in_col        (in_col),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pin_rs    (out_pin_rs),
    .out_pin_enable(out_pin_enable),
    .out_pin_data  (out_pin_data),
    .out_busy_res  (out_busy_res),
    .out_accepted  (out_accepted),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb_char_lcd_write_sequencer NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // bus sequencer predictor: register copies and sequence state
  // ---------------------------------------------------------------------------
  logic [6:0] c_line0 = 7'd0;
  logic [6:0] c_line1 = 7'd64;
  logic [7:0] c_power = 8'd50;
  logic [3:0] c_step = 4'd1;
  logic [3:0] c_long = 4'd2;

  phase_t     m_phase = PH_IDLE;
  logic [7:0] m_wait = 8'd0;
  logic [7:0] m_byte = 8'd0;
  logic       m_is_data = 1'b0;
  logic [2:0] m_init_idx = 3'd0;
  logic       m_rs = 1'b0;
  logic       m_en = 1'b0;
  logic [7:0] m_data = 8'd0;

  function automatic logic [7:0] step_len();
    return (c_step == 4'd0) ? 8'd1 : {4'd0, c_step};
  endfunction

  function automatic void load_byte(input logic [7:0] b, input logic is_data);
    m_byte    = b;
    m_is_data = is_data;
    m_rs      = is_data;
    m_phase   = PH_RS;
    m_wait    = step_len();
  endfunction

  function automatic void byte_done();
    if (m_init_idx >= INIT_FIRST && m_init_idx < INIT_LAST) begin
      m_init_idx = m_init_idx + 3'd1;
      load_byte(INIT_SEQ[m_init_idx], 1'b0);
    end else begin
      m_init_idx = 3'd0;
      m_phase    = PH_IDLE;
      m_wait     = 8'd0;
    end
  endfunction

  // expired waits trigger their action at once; zero waits chain
  function automatic void run_waits();
    while (m_phase != PH_IDLE && m_wait == 8'd0) begin
      case (m_phase)
        PH_POWERUP: begin
          m_rs       = 1'b0;
          m_en       = 1'b0;
          m_init_idx = INIT_FIRST;
          load_byte(INIT_SEQ[INIT_FIRST], 1'b0);
        end
        PH_RS: begin
          m_data  = m_byte;
          m_phase = PH_DATA;
          m_wait  = step_len() << 1;
        end
        PH_DATA: begin
          m_en    = 1'b1;
          m_phase = PH_EHIGH;
          m_wait  = step_len();
        end
        PH_EHIGH: begin
          m_en    = 1'b0;
          m_phase = PH_HOLD;
          m_wait  = step_len() << 1;
        end
        PH_HOLD: begin
          if (!m_is_data && (m_byte == LCD_CLS || m_byte == LCD_HOME)) begin
            m_phase = PH_LONG;
            m_wait  = {4'd0, c_long};
          end else begin
            byte_done();
          end
        end
        default: byte_done();
      endcase
    end
  endfunction

  function automatic pin_state_t lcd_advance(input lcd_req_t r);
    pin_state_t res;
    logic [7:0] col_eff;
    logic [6:0] base;
    logic       taken;
    taken = 1'b0;
    if (m_phase != PH_IDLE) begin
      if (m_wait != 8'd0) m_wait = m_wait - 8'd1;
      run_waits();
    end else begin
      case (r.cmd)
        CMD_BYTE: begin
          taken = 1'b1;
          load_byte(r.value, 1'b0);
        end
        CMD_DATA: begin
          taken = 1'b1;
          load_byte(r.value, 1'b1);
        end
        CMD_CURSOR: begin
          taken   = 1'b1;
          col_eff = (r.col > MAX_COL) ? 8'd0 : r.col;
          base    = (r.row == 2'd1) ? c_line1 : c_line0;
          load_byte({1'b1, base + col_eff[6:0]}, 1'b0);
        end
        CMD_INIT: begin
          taken      = 1'b1;
          m_init_idx = 3'd0;
          m_phase    = PH_POWERUP;
          m_wait     = c_power;
        end
        default: ;
      endcase
      run_waits();
    end
    res.rs    = m_rs;
    res.en    = m_en;
    res.data  = m_data;
    res.busy  = (m_phase != PH_IDLE);
    res.taken = taken;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: bursts of random length with random gaps
  // ---------------------------------------------------------------------------
  lcd_req_t req_q[$];
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    lcd_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (req_q.size() != 0) begin
        r = req_q.pop_front();
        in_valid <= 1'b1;
        in_cmd   <= r.cmd;
        in_value <= r.value;
        in_row   <= r.row;
        in_col   <= r.col;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: changing stall pattern plus recurring long hold-offs
  // ---------------------------------------------------------------------------
  int unsigned seen_out = 0;
  int unsigned next_hold_at = 150;
  int unsigned hold_left = 0;
  int unsigned mode_ctr = 0;
  int unsigned stall_mode = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) seen_out <= seen_out + 1;
      if (mode_ctr == 0) begin
        mode_ctr   <= $urandom_range(20, 80);
        stall_mode <= $urandom_range(0, 2);
      end else begin
        mode_ctr <= mode_ctr - 1;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (seen_out >= next_hold_at) begin
        out_ready    <= 1'b0;
        hold_left    <= 90;
        next_hold_at <= next_hold_at + 270;
      end else begin
        case (stall_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on each input transaction, checks each output one
  // ---------------------------------------------------------------------------
  pin_state_t pin_expq[$];
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_taken = 0;
  int unsigned n_turned_away = 0;
  int unsigned n_fail = 0;

  always @(posedge clk) begin
    pin_state_t want;
    lcd_req_t   r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_results++;
        if (pin_expq.size() == 0) begin
          $error("output transaction with nothing expected");
          n_fail++;
        end else begin
          want = pin_expq.pop_front();
          if (out_pin_rs !== want.rs) begin
            $error("out_pin_rs: expected %0d, got %0d", want.rs, out_pin_rs);
            n_fail++;
          end
          if (out_pin_enable !== want.en) begin
            $error("out_pin_enable: expected %0d, got %0d", want.en, out_pin_enable);
            n_fail++;
          end
          if (out_pin_data !== want.data) begin
            $error("out_pin_data: expected 0x%02h, got 0x%02h", want.data, out_pin_data);
            n_fail++;
          end
          if (out_busy_res !== want.busy) begin
            $error("out_busy_res: expected %0d, got %0d", want.busy, out_busy_res);
            n_fail++;
          end
          if (out_accepted !== want.taken) begin
            $error("out_accepted: expected %0d, got %0d", want.taken, out_accepted);
            n_fail++;
          end
        end
      end
      if (in_valid && in_ready) begin
        r.cmd   = in_cmd;
        r.value = in_value;
        r.row   = in_row;
        r.col   = in_col;
        want = lcd_advance(r);
        pin_expq.push_back(want);
        n_items++;
        if (want.taken) n_taken++;
        else if (r.cmd >= CMD_BYTE && r.cmd <= CMD_INIT) n_turned_away++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  int unsigned n_settings = 1;

  task automatic push_req(input logic [2:0] cmd, input logic [7:0] value,
                          input logic [1:0] row, input logic [7:0] col);
    lcd_req_t r;
    r.cmd   = cmd;
    r.value = value;
    r.row   = row;
    r.col   = col;
    req_q.push_back(r);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (req_q.size() != 0 || in_valid || pin_expq.size() != 0);
  endtask

  // feed ticks until the bus sequence has run out
  task automatic settle_idle();
    drain();
    while (m_phase != PH_IDLE) begin
      repeat (8) push_req(CMD_TICK, 8'($urandom), 2'($urandom), 8'($urandom));
      drain();
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_LINE0_OFFSET:   c_line0 = data[6:0];
      REG_LINE1_OFFSET:   c_line1 = data[6:0];
      REG_POWER_UP_TICKS: c_power = data;
      REG_STEP_TICKS:     c_step  = data[3:0];
      REG_LONG_CMD_TICKS: c_long  = data[3:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input logic [7:0] l0, input logic [7:0] l1, input logic [7:0] pw,
                          input logic [7:0] st, input logic [7:0] lg);
    settle_idle();
    repeat (3) @(posedge clk);
    write_reg(REG_LINE0_OFFSET, l0);
    write_reg(REG_LINE1_OFFSET, l1);
    write_reg(REG_POWER_UP_TICKS, pw);
    write_reg(REG_STEP_TICKS, st);
    write_reg(REG_LONG_CMD_TICKS, lg);
    n_settings++;
  endtask

  // mostly ticks with requests mixed in; many requests land while busy
  task automatic push_random(input int unsigned n);
    int unsigned pick;
    logic [7:0]  v;
    logic [7:0]  c;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      v    = 8'($urandom);
      c    = 8'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 17) : $urandom_range(0, 255));
      if (pick < 55)
        push_req(CMD_TICK, v, 2'($urandom), 8'($urandom));
      else if (pick < 60)
        push_req(3'($urandom_range(5, 7)), v, 2'($urandom), 8'($urandom));
      else if (pick < 73)
        push_req(CMD_DATA, v, 2'($urandom), 8'($urandom));
      else if (pick < 83)
        push_req(CMD_BYTE, ($urandom_range(0, 1) != 0) ? v :
                 (($urandom_range(0, 1) != 0) ? LCD_CLS : LCD_HOME),
                 2'($urandom), 8'($urandom));
      else if (pick < 96)
        push_req(CMD_CURSOR, v, 2'($urandom_range(0, 3)), c);
      else
        push_req(CMD_INIT, v, 2'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at reset settings
    push_req(CMD_DATA, 8'h00, 2'd0, 8'd0);
    settle_idle();
    push_req(CMD_DATA, 8'hFF, 2'd3, 8'hFF);
    settle_idle();
    push_req(CMD_BYTE, LCD_CLS, 2'd0, 8'd0);
    settle_idle();
    push_req(CMD_BYTE, LCD_HOME, 2'd0, 8'd0);
    settle_idle();
    // a data byte of 0x01 gets no long wait
    push_req(CMD_DATA, 8'h01, 2'd0, 8'd0);
    settle_idle();
    push_req(CMD_CURSOR, 8'h00, 2'd1, 8'd15);
    settle_idle();
    push_req(CMD_CURSOR, 8'h00, 2'd0, 8'd16);
    settle_idle();
    push_req(CMD_CURSOR, 8'h00, 2'd2, 8'd255);
    settle_idle();
    push_req(CMD_CURSOR, 8'h00, 2'd3, 8'd7);
    settle_idle();
    // requests and unknown codes during a running init
    push_req(CMD_INIT, 8'h00, 2'd0, 8'd0);
    push_req(CMD_DATA, 8'hA5, 2'd0, 8'd0);
    push_req(3'd5, 8'h00, 2'd0, 8'd0);
    push_req(3'd6, 8'h00, 2'd0, 8'd0);
    push_req(3'd7, 8'h00, 2'd0, 8'd0);
    push_req(CMD_INIT, 8'h00, 2'd0, 8'd0);
    settle_idle();
    push_req(CMD_TICK, 8'hFF, 2'd3, 8'hFF);
    push_req(3'd7, 8'hFF, 2'd3, 8'hFF);
    drain();

    push_random(40);
    // sender holds back until the block has answered everything
    drain();
    push_random(40);

    // wrapped cursor address, zero power-up and zero long wait
    set_regs(8'd127, 8'd0, 8'd0, 8'd1, 8'd0);
    push_req(CMD_CURSOR, 8'h00, 2'd0, 8'd1);
    push_req(CMD_INIT, 8'h00, 2'd0, 8'd0);
    push_random(70);

    // longest power-up and long wait, zero step behaves as one
    set_regs(8'd0, 8'd127, 8'd255, 8'd0, 8'd15);
    push_req(CMD_CURSOR, 8'h00, 2'd1, 8'd15);
    push_random(70);

    set_regs(8'($urandom_range(0, 127)), 8'($urandom_range(0, 127)), 8'd2, 8'd15, 8'd1);
    push_random(70);

    set_regs(8'($urandom_range(0, 127)), 8'($urandom_range(0, 127)),
             8'($urandom_range(0, 30)), 8'($urandom_range(1, 4)),
             8'($urandom_range(0, 15)));
    push_random(70);

    drain();
    repeat (10) @(posedge clk);
    $display("run covered %0d input transactions (%0d requests taken, %0d turned away busy)",
             n_items, n_taken, n_turned_away);
    $display("checked %0d output transactions over %0d register settings",
             n_results, n_settings);
    if (n_fail == 0 && pin_expq.size() == 0) begin
      $display("tb_char_lcd_write_sequencer OK");
    end else begin
      $display("tb_char_lcd_write_sequencer NOT OK");
    end
    $finish;
  end

endmodule

[char_lcd_write_sequencer.f]
hw/rtl/lcdws_pkg.sv
hw/rtl/char_lcd_write_sequencer.sv
tb/sv/tb_char_lcd_write_sequencer.sv
